// ----- rtl/core/page_live_counter_with_region_scan_top_defines.svh -----
// Assertion macros shared by the checker of the page live counter.
// No dependencies; take in by `include where assertions are written.
`ifndef PAGE_LIVE_COUNTER_WITH_REGION_SCAN_TOP_DEFINES_SVH
`define PAGE_LIVE_COUNTER_WITH_REGION_SCAN_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define PLCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PLCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/plcs_pkg.sv -----
// Package for the page live counter with region scan: constants, command
// codes, controller states and the command/status structs. No dependencies.
package plcs_pkg;

   localparam int PAGE_COUNT_DEF = 4096;

   localparam int ADDR_W  = 45;
   localparam int WORDS_W = 32;
   localparam int RIDX_W  = 12;
   localparam int LPW_W   = 5;
   localparam int RW_W    = 25;
   localparam int CSR_W   = 45;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W  = RW_W + RIDX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_PAGE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_WORDS = 2'd2;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RST    = '0;
   localparam logic [LPW_W-1:0]  LOG_PAGE_RST     = 5'd9;
   localparam logic [RW_W-1:0]   REGION_WORDS_RST = 25'd262144;

   typedef enum logic [1:0] {
      CMD_ADD          = 2'd0,
      CMD_CLEAR_REGION = 2'd1,
      CMD_SCAN         = 2'd2,
      CMD_READ         = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_RANGE,
      ST_ROUTE,
      ST_MEM_RD,
      ST_ADD_WR,
      ST_ZERO,
      ST_SCAN_RD,
      ST_SCAN_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic range;
      logic sum_clr;
      logic mem_rd;
      logic add_wr;
      logic zero_wr;
      logic scan_wr;
      logic clr_wr;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    err;
      logic    cnt_zero;
      logic    clr_last;
      logic    rsp_free;
   } dp_stat_type;

endpackage

// ----- rtl/core/page_live_counter_with_region_scan_top.sv -----
// Top level of the page live counter with region scan.
// Depends on plcs_pkg, plcs_ctrl and plcs_datapath.
//
// Requests enter on req_* (valid/stall) and carry a command: add live words
// to the page of a word address, clear a region, turn a region into an
// exclusive prefix sum in place, or read one page counter. Each request gives
// exactly one response on rsp_* (page_value, error); an address or region off
// the table sets error and changes nothing. Heap base, page size and region
// size are to be written on csr_* by the user while the block is idle; the
// block itself does not enforce this. One request is in work at a time. An
// out-of-range request skips the memory work and goes straight to its
// response; an add reads and then writes its page, a region clear makes one
// memory write per page and a scan reads and then writes each page in turn.
// The next request is taken in the cycle after the response is loaded, even
// while it waits. After reset a clearing pass zeroes the counter memory with
// req_stall high; csr writes are taken during it. When rsp_stall is high the
// response holds and the block finishes the next request up to the point of
// loading its response.
module page_live_counter_with_region_scan_top #(
   parameter int PAGE_COUNT = plcs_pkg::PAGE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [plcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plcs_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [plcs_pkg::ADDR_W-1:0]       req_word_address,
   input  logic [plcs_pkg::WORDS_W-1:0]      req_live_words,
   input  logic [plcs_pkg::RIDX_W-1:0]       req_region_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [plcs_pkg::WORDS_W-1:0]      rsp_page_value,
   output logic                              rsp_error
);

   plcs_pkg::dp_cmd_type  dp_cmd;
   plcs_pkg::dp_stat_type dp_stat;

   plcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   plcs_datapath #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_command      (req_command),
      .req_word_address (req_word_address),
      .req_live_words   (req_live_words),
      .req_region_index (req_region_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_page_value   (rsp_page_value),
      .rsp_error        (rsp_error),
      .cmd              (dp_cmd),
      .stat             (dp_stat)
   );

endmodule

// ----- rtl/core/plcs_ctrl.sv -----
// Controller of the page live counter: sequences the clearing pass, range
// checks, memory accesses and region loops. Depends on plcs_pkg.
module plcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  plcs_pkg::dp_stat_type  stat,
   output plcs_pkg::dp_cmd_type   cmd
);

   plcs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plcs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plcs_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = plcs_pkg::ST_IDLE;
         end
         plcs_pkg::ST_IDLE: begin
            if (req_valid) state_in = plcs_pkg::ST_CALC;
         end
         plcs_pkg::ST_CALC:  state_in = plcs_pkg::ST_RANGE;
         plcs_pkg::ST_RANGE: state_in = plcs_pkg::ST_ROUTE;
         plcs_pkg::ST_ROUTE: begin
            if (stat.err) begin
               state_in = plcs_pkg::ST_DONE;
            end else begin
               case (stat.cmd)
                  plcs_pkg::CMD_ADD, plcs_pkg::CMD_READ: state_in = plcs_pkg::ST_MEM_RD;
                  plcs_pkg::CMD_CLEAR_REGION:            state_in = plcs_pkg::ST_ZERO;
                  plcs_pkg::CMD_SCAN:                    state_in = plcs_pkg::ST_SCAN_RD;
                  default:                               state_in = plcs_pkg::ST_DONE;
               endcase
            end
         end
         plcs_pkg::ST_MEM_RD: begin
            state_in = (stat.cmd == plcs_pkg::CMD_ADD) ? plcs_pkg::ST_ADD_WR
                                                       : plcs_pkg::ST_DONE;
         end
         plcs_pkg::ST_ADD_WR: state_in = plcs_pkg::ST_DONE;
         plcs_pkg::ST_ZERO: begin
            if (stat.cnt_zero) state_in = plcs_pkg::ST_DONE;
         end
         plcs_pkg::ST_SCAN_RD: begin
            state_in = stat.cnt_zero ? plcs_pkg::ST_DONE : plcs_pkg::ST_SCAN_WR;
         end
         plcs_pkg::ST_SCAN_WR: state_in = plcs_pkg::ST_SCAN_RD;
         plcs_pkg::ST_DONE: begin
            if (stat.rsp_free) state_in = plcs_pkg::ST_IDLE;
         end
         default: state_in = plcs_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         plcs_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
         plcs_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         plcs_pkg::ST_CALC:    cmd.calc    = 1'b1;
         plcs_pkg::ST_RANGE:   cmd.range   = 1'b1;
         plcs_pkg::ST_ROUTE:   cmd.sum_clr = 1'b1;
         plcs_pkg::ST_MEM_RD:  cmd.mem_rd  = 1'b1;
         plcs_pkg::ST_ADD_WR:  cmd.add_wr  = 1'b1;
         plcs_pkg::ST_ZERO:    cmd.zero_wr = !stat.cnt_zero;
         plcs_pkg::ST_SCAN_RD: cmd.mem_rd  = !stat.cnt_zero;
         plcs_pkg::ST_SCAN_WR: cmd.scan_wr = 1'b1;
         plcs_pkg::ST_DONE:    cmd.rsp_load = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/plcs_datapath.sv -----
// Datapath of the page live counter: configuration registers, address and
// region arithmetic, counter memory and result register. Depends on plcs_pkg.
module plcs_datapath #(
   parameter int PAGE_COUNT = plcs_pkg::PAGE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [plcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plcs_pkg::CSR_W-1:0]        csr_wdata,
   input  logic [1:0]                        req_command,
   input  logic [plcs_pkg::ADDR_W-1:0]       req_word_address,
   input  logic [plcs_pkg::WORDS_W-1:0]      req_live_words,
   input  logic [plcs_pkg::RIDX_W-1:0]       req_region_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [plcs_pkg::WORDS_W-1:0]      rsp_page_value,
   output logic                              rsp_error,
   input  plcs_pkg::dp_cmd_type              cmd,
   output plcs_pkg::dp_stat_type             stat
);

   localparam int PAGE_W = $clog2(PAGE_COUNT);
   localparam int CNT_W  = PAGE_W + 1;
   localparam int AW     = plcs_pkg::ADDR_W;
   localparam int PW     = plcs_pkg::PROD_W;

   logic [AW-1:0]                   base_ff;
   logic [plcs_pkg::LPW_W-1:0]      lpw_ff;
   logic [plcs_pkg::RW_W-1:0]       rw_ff;

   plcs_pkg::cmd_type               cmd_ff;
   logic [AW-1:0]                   addr_ff;
   logic [plcs_pkg::WORDS_W-1:0]    words_ff;
   logic [plcs_pkg::RIDX_W-1:0]     ridx_ff;

   logic [AW:0]                     diff;
   logic [AW-1:0]                   off_ff;
   logic                            below_ff;
   logic [PW-1:0]                   prod_ff;

   logic [AW-1:0]                   page_off;
   logic [PW-1:0]                   first_pg;
   logic [plcs_pkg::RW_W-1:0]       n_pg;
   logic [PW:0]                     span_end;
   logic                            err_in;

   logic                            err_ff;
   logic [PAGE_W-1:0]               ptr_ff, ptr_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [plcs_pkg::WORDS_W-1:0]    sum_ff;

   logic [plcs_pkg::WORDS_W-1:0]    page_mem_ff [PAGE_COUNT];
   logic [plcs_pkg::WORDS_W-1:0]    rdata_ff;
   logic                            wr_en;
   logic [plcs_pkg::WORDS_W-1:0]    wr_data;

   logic                            rsp_valid_ff;
   logic [plcs_pkg::WORDS_W-1:0]    rsp_value_ff;
   logic                            rsp_error_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= plcs_pkg::HEAP_BASE_RST;
         lpw_ff  <= plcs_pkg::LOG_PAGE_RST;
         rw_ff   <= plcs_pkg::REGION_WORDS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            plcs_pkg::CSR_HEAP_BASE:    base_ff <= csr_wdata[AW-1:0];
            plcs_pkg::CSR_LOG_PAGE:     lpw_ff  <= csr_wdata[plcs_pkg::LPW_W-1:0];
            plcs_pkg::CSR_REGION_WORDS: rw_ff   <= csr_wdata[plcs_pkg::RW_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= plcs_pkg::cmd_type'(req_command);
         addr_ff  <= req_word_address;
         words_ff <= req_live_words;
         ridx_ff  <= req_region_index;
      end
   end

   // first stage: heap offset and region start product
   assign diff = {1'b0, addr_ff} - {1'b0, base_ff};

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         off_ff   <= diff[AW-1:0];
         below_ff <= diff[AW];
         prod_ff  <= PW'(rw_ff) * PW'(ridx_ff);
      end
   end

   // second stage: page numbers and bounds
   assign page_off = off_ff >> lpw_ff;
   assign first_pg = prod_ff >> lpw_ff;
   assign n_pg     = rw_ff >> lpw_ff;
   assign span_end = {1'b0, first_pg} + (PW+1)'(n_pg);

   always_comb begin
      if (cmd_ff == plcs_pkg::CMD_ADD || cmd_ff == plcs_pkg::CMD_READ) begin
         err_in = below_ff || (page_off >= AW'(PAGE_COUNT));
      end else begin
         err_in = span_end > (PW+1)'(PAGE_COUNT);
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      if (cmd.range) begin
         if (cmd_ff == plcs_pkg::CMD_ADD || cmd_ff == plcs_pkg::CMD_READ) begin
            ptr_in = page_off[PAGE_W-1:0];
         end else begin
            ptr_in = first_pg[PAGE_W-1:0];
         end
         cnt_in = n_pg[CNT_W-1:0];
      end else if (cmd.zero_wr || cmd.scan_wr) begin
         ptr_in = ptr_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.clr_wr) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.range) err_ff <= err_in;
   end

   // running prefix sum for scans
   always_ff @(posedge clock) begin
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.scan_wr) begin
         sum_ff <= sum_ff + rdata_ff;
      end
   end

   // counter memory: one write and one registered read port
   assign wr_en   = cmd.add_wr || cmd.zero_wr || cmd.scan_wr || cmd.clr_wr;
   assign wr_data = cmd.add_wr  ? rdata_ff + words_ff :
                    cmd.scan_wr ? sum_ff : '0;

   always_ff @(posedge clock) begin
      if (wr_en) page_mem_ff[ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rdata_ff <= page_mem_ff[ptr_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_error_ff <= err_ff;
         rsp_value_ff <= (cmd_ff == plcs_pkg::CMD_READ && !err_ff) ? rdata_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_value = rsp_value_ff;
   assign rsp_error      = rsp_error_ff;

   assign stat.cmd      = cmd_ff;
   assign stat.err      = err_ff;
   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.clr_last = (ptr_ff == PAGE_W'(PAGE_COUNT - 1));
   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ----- rtl/core/plcs_checker.sv -----
// Port-level checker for the page live counter, bound to the top level.
// Depends on page_live_counter_with_region_scan_top_defines.svh.
`include "page_live_counter_with_region_scan_top_defines.svh"

module plcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_page_value,
   input logic        rsp_error
);

   // a stalled response holds
   `PLCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_page_value) && $stable(rsp_error), "stalled response changed")

   // a failed request never reports a counter value
   `PLCS_ASSERT(a_err_zero, clock, reset, rsp_valid && rsp_error |-> rsp_page_value == 32'd0, "error response with non-zero value")

   // an accepted request keeps the block busy in the next cycle
   `PLCS_ASSERT(a_busy_after_req, clock, reset, req_valid && !req_stall |=> req_stall, "request taken while previous one in work")

   // leaving reset starts the clearing pass with no response pending
   `PLCS_ASSERT_ALWAYS(a_clear_after_reset, clock, $fell(reset) |-> req_stall && !rsp_valid, "block not clearing after reset")

endmodule

bind page_live_counter_with_region_scan_top plcs_checker u_plcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_page_value (rsp_page_value),
   .rsp_error      (rsp_error)
);
